[hw/rtl/mzt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mzt_pkg - shared types and constants for the multi-zone one-shot timer
// Request codes, word types for both channels, register indexes and the
// control structs passed between the sequencer and the zone step unit.
// ----------------------------------------------------------------------------
package mzt_pkg;

    // number of zones built
    localparam int ZONES  = 8;
    localparam int ZONE_W = (ZONES > 1) ? $clog2(ZONES) : 1;

    // request codes
    localparam logic [1:0] REQ_TICK     = 2'd0;
    localparam logic [1:0] REQ_START    = 2'd1;
    localparam logic [1:0] REQ_STOP     = 2'd2;
    localparam logic [1:0] REQ_STOP_ALL = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_ZONE_COUNT = 2'd0;
    localparam logic [1:0] CFG_ZONE_IDS   = 2'd1;

    // input word
    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  zone_id;
        logic [31:0] duration_ms;
    } t_req;

    // result word
    typedef struct packed {
        logic [7:0] on_mask;
        logic [7:0] expired_mask;
        logic       any_on;
        logic       id_missing;
    } t_rsp;

    // per-zone control into the step unit
    typedef struct packed {
        logic [1:0] req_type;
        logic       in_use;
        logic       on;
        logic       id_match;
        logic       found;
    } t_zin;

    // per-zone status out of the step unit
    typedef struct packed {
        logic on;
        logic hit;
        logic expired;
    } t_zout;

endpackage

[hw/rtl/mzt_zone_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mzt_zone_step - shared zone update unit
// Computes the next on flag and count of one zone for the current request:
// decrement and zero test on a tick, load on start, clear on stop or stop-all.
// ----------------------------------------------------------------------------
module mzt_zone_step (
    input  mzt_pkg::t_zin  i_ctl,
    input  logic [31:0]    i_rem,
    input  logic [31:0]    i_duration,
    output mzt_pkg::t_zout o_stat,
    output logic [31:0]    o_rem
);
    import mzt_pkg::*;

    logic [31:0] dec;

    // saturating decrement
    assign dec = i_rem - {31'd0, (i_rem != 32'd0)};

    // request decoder
    always_comb begin
        o_stat.on      = i_ctl.on;
        o_stat.hit     = 1'b0;
        o_stat.expired = 1'b0;
        o_rem          = i_rem;
        unique case (i_ctl.req_type)
            REQ_TICK: begin
                if (i_ctl.in_use && i_ctl.on) begin
                    o_rem = dec;
                    if (dec == 32'd0) begin
                        o_stat.on      = 1'b0;
                        o_stat.expired = 1'b1;
                    end
                end
            end
            REQ_START: begin
                if (i_ctl.in_use && i_ctl.id_match && !i_ctl.found) begin
                    o_stat.on  = 1'b1;
                    o_stat.hit = 1'b1;
                    o_rem      = i_duration;
                end
            end
            REQ_STOP: begin
                if (i_ctl.in_use && i_ctl.id_match && !i_ctl.found) begin
                    o_stat.on  = 1'b0;
                    o_stat.hit = 1'b1;
                    o_rem      = 32'd0;
                end
            end
            default: begin
                if (i_ctl.in_use) begin
                    o_stat.on = 1'b0;
                    o_rem     = 32'd0;
                end
            end
        endcase
    end

endmodule

[hw/rtl/multi_zone_one_shot_timer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_zone_one_shot_timer_top - multi-zone one-shot millisecond timer
// Zones matched by configured id are started, stopped and ticked down by a
// sequencer that walks the zones one per cycle through a shared step unit.
// ----------------------------------------------------------------------------
// channel  direction  handshake                 word
// request  in         start & !busy             i_req (t_req)
// result   out        o_done, one cycle pulse   o_rsp (t_rsp)
// config   in         i_cfg_valid & o_cfg_ready i_cfg_index, i_cfg_data
//
// each request keeps busy high while the zones pass one by one through the
// shared step unit; the result strobe follows in the cycle after the last
// zone, when busy is already low, so a new request may be taken in that same
// cycle, but not while busy is high.
// synchronous active-low reset turns every zone off and clears the config
// and sequencer registers; the receiver cannot stall; config is always ready.
// ----------------------------------------------------------------------------
module multi_zone_one_shot_timer_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  mzt_pkg::t_req i_req,
    output logic          o_done,
    output mzt_pkg::t_rsp o_rsp,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data
);
    import mzt_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic              r_state;
    logic [ZONE_W-1:0] r_idx;
    t_req              r_req;
    logic              r_found;
    logic [ZONES-1:0]  r_onm;
    logic [ZONES-1:0]  r_exp;
    logic [ZONES-1:0]  r_on;
    logic [31:0]       r_rem [ZONES];
    logic [3:0]        r_count;
    logic [63:0]       r_ids;
    logic              r_done;
    t_rsp              r_rsp;

    logic [3:0]        zones_used;
    logic              last;
    t_zin              zin;
    t_zout             zout;
    logic [31:0]       rem_nxt;
    logic [ZONES-1:0]  n_onm;
    logic [ZONES-1:0]  n_exp;

    assign busy        = (r_state == ST_SCAN);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_rsp       = r_rsp;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 4'd0;
            r_ids   <= 64'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ZONE_COUNT: r_count <= i_cfg_data[3:0];
                CFG_ZONE_IDS:   r_ids   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zone count saturated to the zones built
    assign zones_used = (r_count > 4'(ZONES)) ? 4'(ZONES) : r_count;
    assign last       = (r_idx == ZONE_W'(ZONES - 1));

    // control for the zone under the cursor
    always_comb begin
        zin.req_type = r_req.req_type;
        zin.in_use   = (4'(r_idx) < zones_used);
        zin.on       = r_on[r_idx];
        zin.id_match = (r_ids[8 * r_idx +: 8] == r_req.zone_id);
        zin.found    = r_found;
    end

    mzt_zone_step u_step (
        .i_ctl      (zin),
        .i_rem      (r_rem[r_idx]),
        .i_duration (r_req.duration_ms),
        .o_stat     (zout),
        .o_rem      (rem_nxt)
    );

    // mask bits gathered for this zone
    always_comb begin
        n_onm        = r_onm;
        n_exp        = r_exp;
        n_onm[r_idx] = zin.in_use && zout.on;
        n_exp[r_idx] = zout.expired;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_found <= 1'b0;
            r_on    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_state <= ST_SCAN;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    r_on[r_idx] <= zout.on;
                    r_found     <= r_found || zout.hit;
                    r_idx       <= r_idx + 1'b1;
                    if (last) begin
                        r_state <= ST_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            if (start) begin
                r_req <= i_req;
                r_onm <= '0;
                r_exp <= '0;
            end
        end else begin
            r_rem[r_idx] <= rem_nxt;
            r_onm        <= n_onm;
            r_exp        <= n_exp;
            if (last) begin
                r_rsp.on_mask      <= 8'(n_onm);
                r_rsp.expired_mask <= 8'(n_exp);
                r_rsp.any_on       <= |n_onm;
                r_rsp.id_missing   <= (r_req.req_type == REQ_START) && !(r_found || zout.hit);
            end
        end
    end

`ifndef SYNTH
    // strobe lasts one cycle and comes only after a scan
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $past(busy))
        else $error("result strobe without a finished scan");

    // a zone that expired cannot be reported on
    a_exp_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.on_mask & o_rsp.expired_mask) == 8'd0)
        else $error("zone both on and expired");

    // missing id only on a start request
    a_missing_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.id_missing) |-> r_req.req_type == REQ_START)
        else $error("id_missing on a request that is not a start");

    // expiry only on a tick
    a_exp_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.expired_mask != 8'd0) |-> r_req.req_type == REQ_TICK)
        else $error("expired mask on a request that is not a tick");
`endif

endmodule

[tb/sv/multi_zone_one_shot_timer_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_zone_one_shot_timer_top_test - self-checking bench for the zone timer
// Sends ticks, starts, stops and stop-alls under a range of zone counts and
// id tables, works out every result word from a local model of the zones and
// compares it field by field as each done strobe arrives.
// ----------------------------------------------------------------------------
module multi_zone_one_shot_timer_top_test;
    import mzt_pkg::*;

    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 50;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    t_req        i_req       = '0;
    logic        o_done;
    t_rsp        o_rsp;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_ZONE_COUNT;
    logic [63:0] i_cfg_data  = '0;

    // local copy of the registers and zone state
    logic [3:0]  zone_count_reg;
    logic [63:0] zone_ids;
    logic [7:0]  zone_on;
    logic [31:0] remaining_ms [8];

    // result words still to come, oldest first
    t_rsp rsp_due [$];
    bit   start_high;
    int   idle_pct;
    int   quiet_cycles = 0;
    int   n_errors, n_items, n_results, n_cfg_writes, n_expiries, n_misses;

    multi_zone_one_shot_timer_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int live_zones();
        return (zone_count_reg > ZONES) ? ZONES : int'(zone_count_reg);
    endfunction

    // advance the zone model by one request and return its result word
    function automatic t_rsp timer_step(input t_req w);
        t_rsp r;
        int   n;
        int   hit;
        n   = live_zones();
        r   = '0;
        hit = -1;
        for (int i = n - 1; i >= 0; i--) begin
            if (zone_ids[8*i +: 8] == w.zone_id) hit = i;
        end
        case (w.req_type)
            REQ_TICK: begin
                for (int i = 0; i < n; i++) begin
                    if (zone_on[i]) begin
                        if (remaining_ms[i] != 0) remaining_ms[i] = remaining_ms[i] - 1;
                        if (remaining_ms[i] == 0) begin
                            zone_on[i]         = 1'b0;
                            r.expired_mask[i] = 1'b1;
                        end
                    end
                end
            end
            REQ_START: begin
                if (hit < 0) begin
                    r.id_missing = 1'b1;
                end else begin
                    zone_on[hit]      = 1'b1;
                    remaining_ms[hit] = w.duration_ms;
                end
            end
            REQ_STOP: begin
                if (hit >= 0) begin
                    zone_on[hit]      = 1'b0;
                    remaining_ms[hit] = '0;
                end
            end
            default: begin
                for (int i = 0; i < n; i++) begin
                    zone_on[i]      = 1'b0;
                    remaining_ms[i] = '0;
                end
            end
        endcase
        for (int i = 0; i < n; i++) r.on_mask[i] = zone_on[i];
        r.any_on = |r.on_mask;
        return r;
    endfunction

    function automatic t_req req_word(input logic [1:0] kind, input logic [7:0] id,
                                      input logic [31:0] dur);
        t_req w;
        w.req_type    = kind;
        w.zone_id     = id;
        w.duration_ms = dur;
        return w;
    endfunction

    // mostly ids of zones in use and short durations, with some noise
    function automatic t_req rand_req();
        t_req        w;
        int unsigned r;
        int          n;
        r = $urandom_range(99);
        if (r < 45)      w.req_type = REQ_TICK;
        else if (r < 75) w.req_type = REQ_START;
        else if (r < 92) w.req_type = REQ_STOP;
        else             w.req_type = REQ_STOP_ALL;
        n = live_zones();
        if (n != 0 && $urandom_range(99) < 80) begin
            w.zone_id = zone_ids[8*$urandom_range(n - 1) +: 8];
        end else begin
            w.zone_id = 8'($urandom);
        end
        r = $urandom_range(99);
        if (r < 70)      w.duration_ms = $urandom_range(6);
        else if (r < 85) w.duration_ms = $urandom_range(40);
        else if (r < 95) w.duration_ms = $urandom;
        else             w.duration_ms = 32'hFFFF_FFFF - $urandom_range(2);
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (n_errors < MAX_REPORTS) begin
            $display("%0t: result %0d %s got 0x%0h want 0x%0h", $realtime, n_results,
                     what, got, want);
        end
        n_errors++;
    endtask

    // send one request word, holding start until it is taken
    task automatic send_word(input t_req w);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            if (start_high) start <= 1'b0;
            start_high = 0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        start      <= 1'b1;
        start_high  = 1;
        i_req      <= w;
        do @(posedge i_clk); while (busy !== 1'b0);
        rsp_due.push_back(timer_step(w));
        n_items++;
    endtask

    // drop start and wait for every outstanding result
    task automatic drain();
        if (start_high) start <= 1'b0;
        start_high = 0;
        do @(posedge i_clk); while (rsp_due.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == CFG_ZONE_COUNT) zone_count_reg = data[3:0];
        else                       zone_ids       = data;
        n_cfg_writes++;
    endtask

    // count goes out with random upper bits, which the block must ignore
    task automatic load_regs(input logic [3:0] count, input logic [63:0] ids);
        write_reg(CFG_ZONE_COUNT,
                  ({32'($urandom), 32'($urandom)} & ~64'hF) | 64'(count));
        write_reg(CFG_ZONE_IDS, ids);
        i_cfg_valid <= 1'b0;
    endtask

    // reset registers: no zone in use, so every start misses
    task automatic test_idle_after_reset();
        idle_pct = 0;
        send_word(req_word(REQ_TICK, 8'h00, 32'd5));
        send_word(req_word(REQ_START, 8'h00, 32'd5));
        send_word(req_word(REQ_STOP, 8'h00, 32'd0));
        send_word(req_word(REQ_STOP_ALL, 8'hFF, 32'hFFFF_FFFF));
    endtask

    // duplicates, zero and maximum durations, restart, unknown ids
    task automatic test_directed_cases();
        drain();
        load_regs(4'd8, 64'h44_33_22_FF_11_00_22_10);
        send_word(req_word(REQ_START, 8'h22, 32'd2));
        send_word(req_word(REQ_START, 8'h00, 32'd0));
        send_word(req_word(REQ_START, 8'hFF, 32'hFFFF_FFFF));
        send_word(req_word(REQ_START, 8'h10, 32'd1));
        send_word(req_word(REQ_TICK, 8'h00, 32'd0));
        send_word(req_word(REQ_START, 8'h22, 32'd5));
        send_word(req_word(REQ_TICK, 8'h00, 32'd0));
        send_word(req_word(REQ_START, 8'h99, 32'd7));
        send_word(req_word(REQ_STOP, 8'h99, 32'd0));
        send_word(req_word(REQ_STOP, 8'hFF, 32'd0));
        send_word(req_word(REQ_START, 8'h44, 32'd3));
        send_word(req_word(REQ_STOP_ALL, 8'h00, 32'd0));
        send_word(req_word(REQ_TICK, 8'h00, 32'd0));
    endtask

    // zones beyond the count keep their state and show again later
    task automatic test_inactive_zones();
        send_word(req_word(REQ_START, 8'h33, 32'd3));
        send_word(req_word(REQ_START, 8'h10, 32'd3));
        drain();
        load_regs(4'd2, zone_ids);
        send_word(req_word(REQ_TICK, 8'h00, 32'd0));
        send_word(req_word(REQ_STOP_ALL, 8'h00, 32'd0));
        drain();
        load_regs(4'd8, zone_ids);
        send_word(req_word(REQ_TICK, 8'h00, 32'd0));
        send_word(req_word(REQ_TICK, 8'h00, 32'd0));
    endtask

    // count above the zone total saturates, count zero matches nothing
    task automatic test_count_extremes();
        drain();
        load_regs(4'd15, 64'h44_33_22_FF_11_00_22_10);
        send_word(req_word(REQ_START, 8'h44, 32'd0));
        send_word(req_word(REQ_TICK, 8'h00, 32'd0));
        drain();
        load_regs(4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(req_word(REQ_START, 8'hFF, 32'd4));
        send_word(req_word(REQ_TICK, 8'h00, 32'd0));
    endtask

    // sender holds off until all results are back, then carries on
    task automatic test_drain_pause();
        drain();
        load_regs(4'd6, {32'($urandom), 32'($urandom)});
        idle_pct = 0;
        repeat (15) send_word(rand_req());
        drain();
        repeat (15) send_word(rand_req());
    endtask

    task automatic run_phase(input int pct, input logic [3:0] count,
                             input logic [63:0] ids, input int items);
        drain();
        load_regs(count, ids);
        idle_pct = pct;
        repeat (items) send_word(rand_req());
    endtask

    // random traffic over several settings and sender idling levels
    task automatic test_random_traffic();
        logic [63:0] dup_ids;
        for (int i = 0; i < 8; i++) begin
            case ($urandom_range(2))
                0:       dup_ids[8*i +: 8] = 8'h00;
                1:       dup_ids[8*i +: 8] = 8'hFF;
                default: dup_ids[8*i +: 8] = 8'h5A;
            endcase
        end
        run_phase(0, 4'd8, {32'($urandom), 32'($urandom)}, 110);
        run_phase(55, 4'd15, dup_ids, 100);
        run_phase(0, 4'd5, {32'($urandom), 32'($urandom)}, 90);
        run_phase(22, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 90);
        run_phase(55, 4'($urandom_range(1, 7)), {32'($urandom), 32'($urandom)}, 90);
        run_phase(22, 4'd8, 64'h0, 40);
    endtask

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done !== 1'b0) begin
            if (rsp_due.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_rsp), 32'd0);
            end else begin
                want = rsp_due.pop_front();
                if (o_rsp.on_mask !== want.on_mask)
                    report_mismatch("on_mask", 32'(o_rsp.on_mask), 32'(want.on_mask));
                if (o_rsp.expired_mask !== want.expired_mask)
                    report_mismatch("expired_mask", 32'(o_rsp.expired_mask),
                                    32'(want.expired_mask));
                if (o_rsp.any_on !== want.any_on)
                    report_mismatch("any_on", 32'(o_rsp.any_on), 32'(want.any_on));
                if (o_rsp.id_missing !== want.id_missing)
                    report_mismatch("id_missing", 32'(o_rsp.id_missing),
                                    32'(want.id_missing));
                n_expiries += $countones(want.expired_mask);
                n_misses   += want.id_missing;
            end
            n_results++;
        end
    end

    // watchdog on cycles with no handshake of any kind
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // test sequence
    initial begin
        zone_count_reg = '0;
        zone_ids       = '0;
        zone_on        = '0;
        foreach (remaining_ms[i]) remaining_ms[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_after_reset();
        test_directed_cases();
        test_inactive_zones();
        test_count_extremes();
        test_drain_pause();
        test_random_traffic();

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (rsp_due.size() != 0) report_mismatch("results missing", rsp_due.size(), 0);

        $display("sent %0d requests, checked %0d result words, %0d register writes",
                 n_items, n_results, n_cfg_writes);
        $display("saw %0d zone expiries and %0d unknown-id starts; %0d mismatches",
                 n_expiries, n_misses, n_errors);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
